// ----- hdl/q2e_pkg.sv -----
// ============================================================================
// q2e_pkg: shared constants and types for the quaternion to Euler block
// Holds the CORDIC arctangent table and the angle format constants.
// ============================================================================
`default_nettype none
package q2e_pkg;
    localparam int TAB_LEN        = 24;
    localparam int CORDIC_STAGES  = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int QUAT_FRAC_BITS = 15;
    localparam int QUAT_W         = 16;
    localparam int ROLL_W         = 16;
    localparam int PITCH_W        = 15;
    localparam int YAW_W          = 16;

    // Angle datapath: Q30 fraction, pi needs 32 bits, plus sign and headroom
    localparam int AW = 34;
    // CORDIC x/y datapath: operands below 2^30, growth under 2^32
    localparam int XW = 34;

    localparam logic [AW-1:0] PI_Q30      = AW'(64'd3373259426);
    localparam logic [AW-1:0] HALF_PI_Q30 = AW'(64'd1686629713);

    typedef logic signed [AW-1:0] t_ang;
    typedef logic signed [XW-1:0] t_xy;

    // atan(2^-i) with 30 fraction bits
    function automatic t_ang atan_tab(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0: v = 32'd843314856;   1: v = 32'd497837829;
                2: v = 32'd263043836;   3: v = 32'd133525158;
                4: v = 32'd67021686;    5: v = 32'd33543515;
                6: v = 32'd16775850;    7: v = 32'd8388437;
                8: v = 32'd4194282;     9: v = 32'd2097149;
                10: v = 32'd1048575;    11: v = 32'd524287;
                12: v = 32'd262143;     13: v = 32'd131071;
                14: v = 32'd65535;      15: v = 32'd32767;
                16: v = 32'd16383;      17: v = 32'd8191;
                18: v = 32'd4095;       19: v = 32'd2047;
                20: v = 32'd1023;       21: v = 32'd511;
                22: v = 32'd255;        23: v = 32'd127;
                default: v = 32'd0;
            endcase
            atan_tab = t_ang'({2'b00, v});
        end
    endfunction
endpackage
`default_nettype wire

// ----- hdl/q2e_if.sv -----
// ============================================================================
// q2e_if: valid/ready channel carrying one item
// Generic payload type; source drives valid and data, sink drives ready.
// ============================================================================
`default_nettype none
interface q2e_if #(parameter type t_data = logic) ();
    logic  valid;
    logic  ready;
    t_data data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/quaternion_to_euler_angles.sv -----
// ============================================================================
// quaternion_to_euler_angles: unit quaternion to roll, pitch, yaw
// Fully pipelined: products, normalization, integer square root for the
// pitch cosine, three unrolled CORDIC vectoring chains, rounding and clamp.
// ============================================================================
// Pipeline: 56 register stages, 6 + 32 + CORDIC_STAGES + 2 at the defaults;
//   the 32-step root sets most of them.
// Throughput: one item per cycle; a stall at the output freezes every stage.
// Reset: synchronous active-low i_rst_n clears all stage valid bits only.
// ============================================================================
`default_nettype none
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS,
    parameter int QUAT_FRAC_BITS  = q2e_pkg::QUAT_FRAC_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    q2e_if.sink       i_quat,
    q2e_if.source     o_euler
);
    import q2e_pkg::*;

    localparam int P_W  = 2 * QUAT_FRAC_BITS + 4;   // product sums
    localparam int SH   = 30 - ANGLE_FRAC_BITS;
    localparam int SQ_N = 32;                       // sqrt result bits
    localparam int NC   = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int NST  = 4 + SQ_N + 2 + NC + 2;

    typedef logic signed [P_W-1:0] t_p;

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves when the output is free
    // ------------------------------------------------------------------
    logic adv;
    logic [NST-1:0] r_vld;
    assign adv = !r_vld[NST-1] || o_euler.ready;
    assign i_quat.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_quat.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: products
    // ------------------------------------------------------------------
    logic signed [QUAT_W-1:0] qw, qx, qy, qz;
    assign qw = i_quat.data[4*QUAT_W-1:3*QUAT_W];
    assign qx = i_quat.data[3*QUAT_W-1:2*QUAT_W];
    assign qy = i_quat.data[2*QUAT_W-1:QUAT_W];
    assign qz = i_quat.data[QUAT_W-1:0];

    t_p r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wx <= P_W'(qw * qx); r_yz <= P_W'(qy * qz);
            r_xx <= P_W'(qx * qx); r_yy <= P_W'(qy * qy);
            r_wy <= P_W'(qw * qy); r_zx <= P_W'(qz * qx);
            r_wz <= P_W'(qw * qz); r_xy <= P_W'(qx * qy);
            r_zz <= P_W'(qz * qz);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sine and cosine terms
    // ------------------------------------------------------------------
    localparam t_p ONE = t_p'(1) <<< (2 * QUAT_FRAC_BITS);
    t_p r_sinr, r_cosr, r_sinp, r_siny, r_cosy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sinr <= (r_wx + r_yz) <<< 1;
            r_cosr <= ONE - ((r_xx + r_yy) <<< 1);
            r_sinp <= (r_wy - r_zx) <<< 1;
            r_siny <= (r_wz + r_xy) <<< 1;
            r_cosy <= ONE - ((r_yy + r_zz) <<< 1);
        end
    end

    // ------------------------------------------------------------------
    // Normalize an atan2 operand pair to sign/magnitude, the larger in [2^29, 2^30)
    // ------------------------------------------------------------------
    typedef struct packed {
        logic        zero;
        logic        sy;
        logic        sx;
        logic [29:0] my;
        logic [29:0] mx;
    } t_norm;

    function automatic t_norm norm_pair(input t_p y, input t_p x);
        t_norm       r;
        logic [P_W-1:0] ay, ax, o;
        logic [P_W+29:0] ey, ex;
        int          msb;
        begin
            ay = y[P_W-1] ? P_W'(-y) : P_W'(y);
            ax = x[P_W-1] ? P_W'(-x) : P_W'(x);
            o = ay | ax;
            msb = 0;
            for (int b = 0; b < P_W; b++) if (o[b]) msb = b;
            ey = {ay, 30'd0} >> (msb + 1);
            ex = {ax, 30'd0} >> (msb + 1);
            r.zero = (o == '0);
            r.sy = y[P_W-1];
            r.sx = x[P_W-1];
            r.my = ey[29:0];
            r.mx = ex[29:0];
            norm_pair = r;
        end
    endfunction

    // Stage 2: normalize roll and yaw; prepare pitch sine
    t_norm r_nr, r_ny;
    logic        r_clamp, r_psgn;
    logic [29:0] r_ms;
    logic [P_W-1:0] amag;
    logic [P_W+29:0] msx;
    assign amag = r_sinp[P_W-1] ? P_W'(-r_sinp) : P_W'(r_sinp);
    assign msx  = {amag, 30'd0} >> (2 * QUAT_FRAC_BITS);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nr    <= norm_pair(r_sinr, r_cosr);
            r_ny    <= norm_pair(r_siny, r_cosy);
            r_clamp <= (amag >= P_W'(ONE));
            r_psgn  <= r_sinp[P_W-1];
            r_ms    <= msx[29:0];
        end
    end

    // ------------------------------------------------------------------
    // Square-root stages: floor(sqrt(2^60 - ms^2)), one bit per stage.
    // First stage forms the radicand; roll/yaw pairs ride alongside.
    // ------------------------------------------------------------------
    typedef struct packed {
        t_norm       nr;
        t_norm       ny;
        logic        clamp;
        logic        psgn;
        logic [29:0] ms;
        logic [61:0] rem;
        logic [31:0] root;
    } t_sq;

    t_sq r_sq [SQ_N+1];
    t_sq n_sq [SQ_N+1];
    always_comb begin
        logic [63:0] trial, rem_w;
        n_sq[0].nr    = r_nr;
        n_sq[0].ny    = r_ny;
        n_sq[0].clamp = r_clamp;
        n_sq[0].psgn  = r_psgn;
        n_sq[0].ms    = r_ms;
        n_sq[0].rem   = 62'((64'd1 << 60) - 64'(r_ms) * 64'(r_ms));
        n_sq[0].root  = '0;
        // Try the next root bit; keep it when the remainder allows
        for (int k = 0; k < SQ_N; k++) begin
            rem_w = 64'(r_sq[k].rem);
            trial = ({32'd0, r_sq[k].root} << (SQ_N - k))
                    | (64'd1 << (2 * (SQ_N - 1 - k)));
            n_sq[k+1] = r_sq[k];
            if (rem_w >= trial) begin
                n_sq[k+1].rem  = 62'(rem_w - trial);
                n_sq[k+1].root = r_sq[k].root | (32'd1 << (SQ_N - 1 - k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq <= n_sq;
        end
    end

    // Pitch pair normalize (root fits under 2^31)
    t_norm r_np, r_nr2, r_ny2;
    logic  r_clamp2, r_psgn2;
    t_p    ps_y, ps_x;
    assign ps_y = r_sq[SQ_N].psgn ? -t_p'(r_sq[SQ_N].ms) : t_p'(r_sq[SQ_N].ms);
    assign ps_x = t_p'(r_sq[SQ_N].root);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_np     <= norm_pair(ps_y, ps_x);
            r_nr2    <= r_sq[SQ_N].nr;
            r_ny2    <= r_sq[SQ_N].ny;
            r_clamp2 <= r_sq[SQ_N].clamp;
            r_psgn2  <= r_sq[SQ_N].psgn;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring, one micro-rotation per stage, three lanes
    // ------------------------------------------------------------------
    typedef struct packed {
        logic zero;
        t_xy  x;
        t_xy  y;
        t_ang z;
    } t_cl;

    function automatic t_cl cl_init(input t_norm n);
        t_cl c;
        t_xy yv;
        begin
            yv = n.sy ? -t_xy'(n.my) : t_xy'(n.my);
            c.zero = n.zero;
            c.x = t_xy'(n.mx);
            c.y = yv;
            c.z = '0;
            if (n.sx) begin
                c.z = (yv >= 0) ? t_ang'(PI_Q30) : -t_ang'(PI_Q30);
                c.y = -yv;
            end
            cl_init = c;
        end
    endfunction

    function automatic t_cl cl_step(input t_cl c, input int i);
        t_cl r;
        begin
            r = c;
            if (c.y > 0) begin
                r.x = c.x + (c.y >>> i);
                r.y = c.y - (c.x >>> i);
                r.z = c.z + atan_tab(i);
            end else begin
                r.x = c.x - (c.y >>> i);
                r.y = c.y + (c.x >>> i);
                r.z = c.z - atan_tab(i);
            end
            cl_step = r;
        end
    endfunction

    t_cl  r_cr [NC+1], r_cp [NC+1], r_cy [NC+1];
    t_cl  n_cr [NC+1], n_cp [NC+1], n_cy [NC+1];
    logic r_cc [NC+1], n_cc [NC+1];
    logic r_cs [NC+1], n_cs [NC+1];
    always_comb begin
        n_cr[0] = cl_init(r_nr2);
        n_cp[0] = cl_init(r_np);
        n_cy[0] = cl_init(r_ny2);
        n_cc[0] = r_clamp2;
        n_cs[0] = r_psgn2;
        for (int i = 0; i < NC; i++) begin
            n_cr[i+1] = cl_step(r_cr[i], i);
            n_cp[i+1] = cl_step(r_cp[i], i);
            n_cy[i+1] = cl_step(r_cy[i], i);
            n_cc[i+1] = r_cc[i];
            n_cs[i+1] = r_cs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cr <= n_cr;
            r_cp <= n_cp;
            r_cy <= n_cy;
            r_cc <= n_cc;
            r_cs <= n_cs;
        end
    end

    // ------------------------------------------------------------------
    // Round half up and saturate
    // ------------------------------------------------------------------
    function automatic t_ang rnd(input t_ang z);
        rnd = (z + (t_ang'(1) <<< (SH - 1))) >>> SH;
    endfunction

    localparam t_ang PI_Q  = (t_ang'(PI_Q30) + (t_ang'(1) <<< (SH - 1))) >>> SH;
    localparam t_ang HPI_Q = (t_ang'(HALF_PI_Q30) + (t_ang'(1) <<< (SH - 1))) >>> SH;

    function automatic t_ang sat(input t_ang v, input t_ang lim);
        if (v > lim) sat = lim;
        else if (v < -lim) sat = -lim;
        else sat = v;
    endfunction

    t_ang r_rr, r_rp, r_ry;
    logic r_rc, r_rs;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rr <= r_cr[NC].zero ? '0 : rnd(r_cr[NC].z);
            r_rp <= r_cp[NC].zero ? '0 : rnd(r_cp[NC].z);
            r_ry <= r_cy[NC].zero ? '0 : rnd(r_cy[NC].z);
            r_rc <= r_cc[NC];
            r_rs <= r_cs[NC];
        end
    end

    // Output register
    t_ang pv;
    logic [ROLL_W-1:0]  r_roll;
    logic [PITCH_W-1:0] r_pitch;
    logic [YAW_W-1:0]   r_yaw;
    logic               r_pclamp;
    assign pv = r_rc ? (r_rs ? -HPI_Q : HPI_Q) : sat(r_rp, HPI_Q);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll   <= ROLL_W'(sat(r_rr, PI_Q));
            r_yaw    <= YAW_W'(sat(r_ry, PI_Q));
            r_pitch  <= PITCH_W'(pv);
            r_pclamp <= r_rc;
        end
    end

    assign o_euler.valid = r_vld[NST-1];
    assign o_euler.data  = {r_roll, r_pitch, r_yaw, r_pclamp};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid && !o_euler.ready |=> o_euler.valid && $stable(o_euler.data))
        else $error("output item changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_euler.valid |-> i_quat.ready)
        else $error("input stalled with empty output");
    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-1] && r_pclamp |->
            (r_pitch == PITCH_W'(HPI_Q) || r_pitch == PITCH_W'(-HPI_Q)))
        else $error("clamped pitch not at half pi");
endmodule
`default_nettype wire
